// File: hw/rtl/vldec_pkg.sv
package vldec_pkg;

  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned COUNT_BITS = 4;
  localparam int unsigned SHIFT_BITS = 6;

  localparam logic [COUNT_BITS-1:0] MAX_BYTES = 4'd10;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LONG  = 2'd1,
    STAT_UNEXP_END = 2'd2
  } status_e;

  typedef struct packed {
    logic                  emit;
    logic [VALUE_BITS-1:0] value;
    status_e               status;
    logic [VALUE_BITS-1:0] acc_next;
    logic [COUNT_BITS-1:0] count_next;
  } step_t;

endpackage

// File: hw/rtl/vldec_if.sv
interface vldec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface vldec_out_if;
  logic                 valid;
  logic                 ready;
  logic [63:0]          value;
  vldec_pkg::status_e   status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// File: hw/rtl/vldec_step.sv
module vldec_step (
  input  logic [vldec_pkg::VALUE_BITS-1:0] acc_i,
  input  logic [vldec_pkg::COUNT_BITS-1:0] count_i,
  input  logic [7:0]                       in_byte_i,
  input  logic                             stream_end_i,
  input  logic                             signed_mode_i,
  output vldec_pkg::step_t                 step_o
);
  import vldec_pkg::*;

  logic [6:0]            shift_full;
  logic [SHIFT_BITS-1:0] shift;
  logic [VALUE_BITS-1:0] group_sh;
  logic [VALUE_BITS-1:0] acc_add;
  logic [VALUE_BITS-1:0] unzz;

  // count <= 10; count*7 tops out at 63 for count < 10
  assign shift_full = {3'b000, count_i} * 7'd7;
  assign shift      = shift_full[SHIFT_BITS-1:0];
  assign group_sh   = {{(VALUE_BITS-GROUP_BITS){1'b0}}, in_byte_i[GROUP_BITS-1:0]} << shift;
  assign acc_add    = acc_i | group_sh;
  assign unzz       = {1'b0, acc_add[VALUE_BITS-1:1]} ^ {VALUE_BITS{acc_add[0]}};

  always_comb begin
    step_o            = '0;
    step_o.status     = STAT_OK;
    if (count_i >= MAX_BYTES) begin
      step_o.emit   = 1'b1;
      step_o.status = STAT_TOO_LONG;
    end else if (!in_byte_i[7]) begin
      step_o.emit  = 1'b1;
      step_o.value = signed_mode_i ? unzz : acc_add;
    end else if (stream_end_i) begin
      step_o.emit   = 1'b1;
      step_o.status = STAT_UNEXP_END;
    end else begin
      step_o.acc_next   = acc_add;
      step_o.count_next = count_i + 4'd1;
    end
  end

endmodule

// File: hw/rtl/varint_leb128_stream_decoder.sv
// LEB128 varint stream decoder, one byte per beat, optional zigzag on output.
// An accepted input beat passes the input register, then the result register;
// bytes that end no value give no beat. Throughput: 1 byte per cycle while no
// result waits on out_if.ready; the accumulator shift-or is one pass.
// Reset (rst_ni low, async): pipeline empty, accumulator and count cleared,
// signed mode off.
module varint_leb128_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  vldec_in_if.sink    in_if,
  vldec_out_if.source out_if
);
  import vldec_pkg::*;

  logic                  signed_mode_q;
  logic                  in_vld_q;
  logic [7:0]            byte_q;
  logic                  end_q;
  logic [VALUE_BITS-1:0] acc_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  out_vld_q;
  logic [VALUE_BITS-1:0] value_q;
  status_e               status_q;

  logic  out_free;
  logic  proc_fire;
  logic  in_rdy;
  step_t step;

  assign out_free  = !out_vld_q || out_if.ready;
  assign proc_fire = in_vld_q && out_free;
  assign in_rdy    = !in_vld_q || proc_fire;

  assign in_if.ready   = in_rdy;
  assign out_if.valid  = out_vld_q;
  assign out_if.value  = value_q;
  assign out_if.status = status_q;

  vldec_step u_step (
    .acc_i         (acc_q),
    .count_i       (count_q),
    .in_byte_i     (byte_q),
    .stream_end_i  (end_q),
    .signed_mode_i (signed_mode_q),
    .step_o        (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      acc_q         <= '0;
      count_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        signed_mode_q <= cfg_wdata_i;
      end
      if (in_rdy) begin
        in_vld_q <= in_if.valid;
      end
      if (proc_fire) begin
        out_vld_q <= step.emit;
        acc_q     <= step.acc_next;
        count_q   <= step.count_next;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_rdy) begin
      byte_q <= in_if.in_byte;
      end_q  <= in_if.stream_end;
    end
    if (proc_fire && step.emit) begin
      value_q  <= step.value;
      status_q <= step.status;
    end
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_BYTES)
    else $error("byte count beyond limit");

  a_acc_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (acc_q == '0))
    else $error("accumulator not cleared at value start");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q != STAT_OK) |-> (value_q == '0))
    else $error("error result carries nonzero value");

  a_in_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc_fire) |=> (in_vld_q && $stable(byte_q) && $stable(end_q)))
    else $error("pending input byte lost");

  a_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_if.ready) |=> out_vld_q)
    else $error("stalled result dropped");

endmodule

// File: test/varint_leb128_stream_decoder_tb.sv
module varint_leb128_stream_decoder_tb;
  import vldec_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    status_e               status;
  } varint_result_t;

  // Tracks the decoder state and holds the results still owed by the block.
  class varint_tracker;
    logic [VALUE_BITS-1:0] acc;
    logic [COUNT_BITS-1:0] count;
    bit                    signed_mode;
    varint_result_t        owed_results[$];
    int                    errors;

    function new();
      acc         = '0;
      count       = '0;
      signed_mode = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void push_result(logic [VALUE_BITS-1:0] v, status_e s);
      varint_result_t r;
      r.value  = v;
      r.status = s;
      owed_results = {owed_results, r};
      acc   = '0;
      count = '0;
    endfunction

    function void take_byte(logic [7:0] data, logic is_last);
      logic [VALUE_BITS-1:0] v;
      if (count >= MAX_BYTES) begin
        // eleventh byte: swallowed whatever it holds
        push_result('0, STAT_TOO_LONG);
        return;
      end
      acc   = acc | ({{(VALUE_BITS-GROUP_BITS){1'b0}}, data[6:0]} << (int'(count) * GROUP_BITS));
      count = count + 1'b1;
      if (!data[7]) begin
        v = acc;
        if (signed_mode)
          v = (v >> 1) ^ {VALUE_BITS{v[0]}};
        push_result(v, STAT_OK);
      end else if (is_last) begin
        push_result('0, STAT_UNEXP_END);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task match_result(logic [VALUE_BITS-1:0] v, status_e s);
      varint_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with nothing owed: value=%h status=%0d", v, s));
        return;
      end
      want = owed_results.pop_front();
      if (s !== want.status)
        report($sformatf("status %0d, want %0d", s, want.status));
      if (v !== want.value)
        report($sformatf("value %h, want %h", v, want.value));
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_BYTES    = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  vldec_in_if  byte_bus ();
  vldec_out_if value_bus ();

  varint_leb128_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (byte_bus),
    .out_if      (value_bus)
  );

  varint_tracker tracker = new();

  int in_gap_pct;
  int out_gap_pct;
  int out_hold;
  int quiet_cycles;
  int bytes_sent;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_hold        <= out_hold - 1;
      value_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_gap_pct) begin
      out_hold        <= pick_gap() - 1;
      value_bus.ready <= 1'b0;
    end else begin
      value_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (value_bus.valid && value_bus.ready)
      tracker.match_result(value_bus.value, value_bus.status);
  end

  always @(posedge clk_i) begin
    if ((byte_bus.valid && byte_bus.ready) || (value_bus.valid && value_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] data, input logic is_last);
    int gap;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = pick_gap();
      byte_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.in_byte    <= data;
    byte_bus.stream_end <= is_last;
    do @(posedge clk_i); while (!byte_bus.ready);
    tracker.take_byte(data, is_last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_cont(input int n);
    repeat (n) send_byte({1'b1, 7'($urandom)}, 1'b0);
  endtask

  task automatic drain();
    byte_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_signed_mode(input bit m);
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.signed_mode = m;
  endtask

  task automatic send_random_stream(input int n_bytes);
    int target;
    int r;
    int len;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 9) : 10;
        repeat (len - 1) send_byte({1'b1, 7'($urandom)}, $urandom_range(0, 49) == 0);
        send_byte({1'b0, 7'($urandom)}, $urandom_range(0, 9) == 0);
      end else if (r < 80) begin
        // overlong value
        send_cont(10);
        send_byte(8'($urandom), 1'($urandom));
      end else if (r < 90) begin
        // stream cut inside a value
        send_cont($urandom_range(0, 9));
        send_byte({1'b1, 7'($urandom)}, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'($urandom));
      end
    end
    // close any open value before the phase ends
    send_byte(8'h00, 1'b0);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = 1'b0;
    byte_bus.valid      = 1'b0;
    byte_bus.in_byte    = 8'h00;
    byte_bus.stream_end = 1'b0;
    value_bus.ready     = 1'b0;
    in_gap_pct          = 25;
    out_gap_pct         = 25;
    out_hold            = 0;
    quiet_cycles        = 0;
    bytes_sent          = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, unsigned
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    // ten bytes, tenth payload mostly dropped: all ones
    repeat (9) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // eleventh byte
    repeat (10) send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h05, 1'b1);
    drain();

    // directed, zigzag
    set_signed_mode(1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h7F, 1'b0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          in_gap_pct  = 25;
          out_gap_pct = 25;
        end
        1: begin
          set_signed_mode(1'b0);
          in_gap_pct  = 0;
          out_gap_pct = 0;
        end
        2: begin
          set_signed_mode(1'b1);
          in_gap_pct  = 5;
          out_gap_pct = 60;
        end
        3: begin
          set_signed_mode(1'b0);
          in_gap_pct  = 50;
          out_gap_pct = 10;
        end
        default: begin
          set_signed_mode(1'b1);
          in_gap_pct  = 20;
          out_gap_pct = 30;
        end
      endcase
      send_random_stream(PHASE_BYTES);
      drain();
    end

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
